### design/srfc_pkg.sv
// Package for the serial reply frame checker: command and status codes,
// frame size constants, framing characters and small helper functions.
// Used by serial_reply_frame_checker; depends on nothing else.
package srfc_pkg;

  localparam int FRAME_BYTES = 33;
  localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
  localparam int PAYLOAD_W   = 5;

  localparam logic [1:0] CMD_BYTE    = 2'd0;
  localparam logic [1:0] CMD_ARM     = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CSUM    = 2'd1,
    ST_PREFIX  = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_t;

  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_O      = 8'h4F;
  localparam logic [7:0] CH_K      = 8'h4B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_A      = 8'h41;

  localparam logic [3:0] MAX_RETRIES_RST = 4'd4;
  localparam logic [3:0] RETRIES_SAT     = 4'd15;

  localparam int PREFIX_LEN   = 3;
  localparam int CSUM_MIN_LEN = 4;
  localparam int OK_MIN_LEN   = 7;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] d;
    if (v < 4'd10) begin
      d = CH_ZERO + {4'd0, v};
    end else begin
      d = CH_A + {4'd0, v} - 8'd10;
    end
    return d;
  endfunction

  function automatic logic [7:0] lead_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = CH_DOLLAR;
      2'd1:    c = CH_O;
      default: c = CH_K;
    endcase
    return c;
  endfunction

endpackage

### design/serial_reply_frame_checker.sv
// Serial reply frame checker top level: per-byte frame state, checksum and
// prefix checks, retry counting and the registered result channel.
// Depends on srfc_pkg.
//
// Usage: after a command goes out, send an arm transaction (cmd 1). Received
// UART bytes then come in as cmd 0 transactions with their overrun flag; a
// response timeout is reported as cmd 2. A carriage return closes an armed
// frame that saw no overrun or overflow, and one result transaction gives
// status, retry count, exhaustion flag and payload length. A timeout while a
// reply is pending gives a timeout result. A result appears on the output in
// the cycle after the closing transaction is accepted. The block takes one
// input transaction per cycle unless stalled; the input is stalled only while
// a result sits in the output register and the receiver stalls it. Reset
// clears all frame state, the retry count, and loads max_retries with 4. The
// max_retries register is written through cfg_wr_en and cfg_wr_data; the user
// must write it only while the block is idle, which the block does not enforce.
module serial_reply_frame_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_data_byte,
  input  logic       in_overrun,
  output logic       out_valid,
  input  logic       out_stall,
  output srfc_pkg::status_t out_status,
  output logic [3:0] out_retries,
  output logic       out_retries_exhausted,
  output logic [srfc_pkg::PAYLOAD_W-1:0] out_payload_length
);
  import srfc_pkg::*;

  logic [3:0]           max_ret_r;
  logic                 pending_r, pending_nxt;
  logic                 awaiting_r, awaiting_nxt;
  logic                 error_r, error_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [7:0]           xor_r, xor_nxt;
  logic                 xor_stop_r, xor_stop_nxt;
  logic                 prefix_ok_r, prefix_ok_nxt;
  logic [7:0]           older_r, older_nxt;
  logic [7:0]           newer_r, newer_nxt;
  logic [3:0]           err_cnt_r, err_cnt_nxt;

  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, res_status;
  logic [3:0]           out_retries_r;
  logic                 out_exh_r, res_exh;
  logic [PAYLOAD_W-1:0] out_payload_r, res_payload;

  logic                 in_acc;
  logic                 res_valid;
  logic                 err_now;
  logic [CNT_W-1:0]     len_diff;

  assign in_stall      = out_valid_r & out_stall;
  assign in_acc        = in_valid & ~in_stall;

  always_comb begin
    pending_nxt   = pending_r;
    awaiting_nxt  = awaiting_r;
    error_nxt     = error_r;
    count_nxt     = count_r;
    xor_nxt       = xor_r;
    xor_stop_nxt  = xor_stop_r;
    prefix_ok_nxt = prefix_ok_r;
    older_nxt     = older_r;
    newer_nxt     = newer_r;
    res_valid     = 1'b0;
    res_status    = ST_OK;
    res_payload   = '0;
    err_now       = error_r;
    len_diff      = '0;

    case (in_cmd)
      CMD_ARM: begin
        pending_nxt = 1'b1;
        awaiting_nxt = 1'b1;
        error_nxt = 1'b0;
        count_nxt = '0;
        xor_nxt = '0;
        xor_stop_nxt = 1'b0;
        prefix_ok_nxt = 1'b1;
        older_nxt = '0;
        newer_nxt = '0;
      end
      CMD_TIMEOUT: begin
        if (pending_r) begin
          res_valid = 1'b1;
          res_status = ST_TIMEOUT;
        end
      end
      CMD_BYTE: begin
        err_now = error_r | in_overrun | (count_r >= CNT_W'(FRAME_BYTES));
        error_nxt = err_now;
        if (!err_now && awaiting_r) begin
          if (count_r < CNT_W'(PREFIX_LEN)) begin
            if (in_data_byte != lead_char(count_r[1:0])) begin
              prefix_ok_nxt = 1'b0;
            end
          end
          if (!xor_stop_r) begin
            if (in_data_byte == CH_CARET || in_data_byte == 8'd0) begin
              xor_stop_nxt = 1'b1;
            end else begin
              xor_nxt = xor_r ^ in_data_byte;
            end
          end
          count_nxt = count_r + CNT_W'(1);
          if (in_data_byte != CH_CR) begin
            older_nxt = newer_r;
            newer_nxt = in_data_byte;
          end else begin
            res_valid = 1'b1;
            len_diff = count_nxt - CNT_W'(OK_MIN_LEN);
            if (count_nxt < CNT_W'(CSUM_MIN_LEN) ||
                older_r != hex_digit(xor_nxt[7:4]) ||
                newer_r != hex_digit(xor_nxt[3:0])) begin
              res_status = ST_CSUM;
            end else if (count_nxt < CNT_W'(OK_MIN_LEN) || !prefix_ok_nxt) begin
              res_status = ST_PREFIX;
            end else if (len_diff > CNT_W'((1 << PAYLOAD_W) - 1)) begin
              res_payload = '1;
            end else begin
              res_payload = len_diff[PAYLOAD_W-1:0];
            end
          end
        end
      end
      default: begin
      end
    endcase

    if (res_valid) begin
      pending_nxt = 1'b0;
      awaiting_nxt = 1'b0;
      error_nxt = 1'b0;
      count_nxt = '0;
      xor_nxt = '0;
      xor_stop_nxt = 1'b0;
      prefix_ok_nxt = 1'b1;
      older_nxt = '0;
      newer_nxt = '0;
    end
  end

  always_comb begin
    err_cnt_nxt = err_cnt_r;
    res_exh = 1'b0;
    if (res_valid) begin
      if (res_status == ST_OK) begin
        err_cnt_nxt = '0;
      end else begin
        res_exh = (err_cnt_r >= max_ret_r);
        if (err_cnt_r != RETRIES_SAT) begin
          err_cnt_nxt = err_cnt_r + 4'd1;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (in_acc && res_valid) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_ret_r   <= MAX_RETRIES_RST;
      pending_r   <= 1'b0;
      awaiting_r  <= 1'b0;
      error_r     <= 1'b0;
      count_r     <= '0;
      xor_r       <= '0;
      xor_stop_r  <= 1'b0;
      prefix_ok_r <= 1'b1;
      older_r     <= '0;
      newer_r     <= '0;
      err_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_ret_r <= cfg_wr_data;
      end
      if (in_acc) begin
        pending_r   <= pending_nxt;
        awaiting_r  <= awaiting_nxt;
        error_r     <= error_nxt;
        count_r     <= count_nxt;
        xor_r       <= xor_nxt;
        xor_stop_r  <= xor_stop_nxt;
        prefix_ok_r <= prefix_ok_nxt;
        older_r     <= older_nxt;
        newer_r     <= newer_nxt;
        err_cnt_r   <= err_cnt_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      out_status_r  <= res_status;
      out_retries_r <= err_cnt_nxt;
      out_exh_r     <= res_exh;
      out_payload_r <= res_payload;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_retries           = out_retries_r;
  assign out_retries_exhausted = out_exh_r;
  assign out_payload_length    = out_payload_r;

  a_ok_clears_retries : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |-> out_retries == 4'd0 && !out_retries_exhausted)
    else $error("ok result with nonzero retry count or exhaustion flag");

  a_err_no_payload : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_payload_length == '0 && out_retries != 4'd0)
    else $error("error result with payload length or zero retry count");

  a_arm_restarts : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_cmd == CMD_ARM |=> pending_r && awaiting_r && !error_r && count_r == '0)
    else $error("arm transaction did not restart the frame");

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(FRAME_BYTES) && (count_r == '0 || pending_r))
    else $error("byte count beyond frame size or held with no reply pending");

endmodule
